// File: src/asep_pkg.sv
// ----------------------------------------------------------------------------
// asep_pkg
// shared widths, constants and the cordic arctangent table
// ----------------------------------------------------------------------------
`default_nettype none

package asep_pkg;

  localparam int unsigned ANGLE_FRAC_BITS_DEF   = 20;
  localparam int unsigned CORDIC_ITERATIONS_DEF = 24;

  // wide angle in degrees times 2^32
  localparam int unsigned WIDE_W = 64;
  // reduced angle / cordic z, degrees times 2^32
  localparam int unsigned Z_W    = 42;
  // cordic x and y in q30
  localparam int unsigned XY_W   = 33;
  // haversine term in q30, 0 to 1
  localparam int unsigned A_W    = 31;
  // square root operand and remainder
  localparam int unsigned SQ_W   = 62;
  localparam int unsigned SQ_STEPS = 31;
  localparam int unsigned ROOT_W = 31;
  // modulo 360 reduction: upper part of the angle taken modulo 45
  localparam int unsigned LO_W      = 35;
  localparam int unsigned HI_W      = 30;
  localparam int unsigned RED_STEPS = 24;
  localparam int unsigned SEP_W     = 28;

  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [Z_W-1:0]    zang_t;
  typedef logic signed [XY_W-1:0]   xy_t;

  localparam logic [HI_W-1:0] HI_OFFSET = 30'd377487360;  // 45 * 2^23
  localparam logic [HI_W-1:0] MOD_BASE  = 30'd45;

  localparam zang_t DEG_FULL    = 42'sd1546188226560;
  localparam zang_t DEG_HALF    = 42'sd773094113280;
  localparam zang_t DEG_QUARTER = 42'sd386547056640;

  localparam xy_t GAIN_Q30 = 33'sd652032874;
  localparam logic [A_W-1:0] ONE_Q30 = 31'd1073741824;

  localparam longint unsigned SEP_FIELD_MAX = 64'd268435455;
  localparam logic [39:0] RAD_IN_DEG_Q32 = 40'd246083499208;

  // atan(2^-i) in degrees times 2^32
  function automatic logic [39:0] atan_step(input int unsigned i);
    logic [39:0] v;
    case (i)
      0:  v = 40'd193273528320;
      1:  v = 40'd114096026022;
      2:  v = 40'd60285206653;
      3:  v = 40'd30601712202;
      4:  v = 40'd15360239180;
      5:  v = 40'd7687607525;
      6:  v = 40'd3844741810;
      7:  v = 40'd1922488225;
      8:  v = 40'd961258780;
      9:  v = 40'd480631223;
      10: v = 40'd240315841;
      11: v = 40'd120157949;
      12: v = 40'd60078978;
      13: v = 40'd30039489;
      14: v = 40'd15019745;
      15: v = 40'd7509872;
      default: v = RAD_IN_DEG_Q32 >> i;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: src/asep_angle.sv
// ----------------------------------------------------------------------------
// asep_angle
// pipelined reduction of a wide angle into [-90, 90] degrees with fold flag
// ----------------------------------------------------------------------------
`default_nettype none

module asep_angle (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire asep_pkg::wide_t ang_i,
  output asep_pkg::zang_t     z_o,
  output logic                neg_o
);

  localparam int unsigned N = asep_pkg::RED_STEPS;

  logic [asep_pkg::HI_W-1:0] v_q  [N];
  logic [asep_pkg::LO_W-1:0] lo_q [N];

  // upper part made positive by adding a multiple of 45
  logic [asep_pkg::HI_W-1:0] hi_u;
  assign hi_u = asep_pkg::HI_W'($signed(ang_i[asep_pkg::WIDE_W-1:asep_pkg::LO_W]))
              + asep_pkg::HI_OFFSET;

  for (genvar j = 0; j < N; j++) begin : g_step
    logic [asep_pkg::HI_W-1:0] vi, sub;
    logic [asep_pkg::LO_W-1:0] li;
    if (j == 0) begin : g_first
      assign vi = hi_u;
      assign li = ang_i[asep_pkg::LO_W-1:0];
    end else begin : g_next
      assign vi = v_q[j-1];
      assign li = lo_q[j-1];
    end
    assign sub = asep_pkg::MOD_BASE << (N - 1 - j);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[j]  <= (vi >= sub) ? vi - sub : vi;
        lo_q[j] <= li;
      end
    end
  end

  // wrap to [-180, 180) then fold by 180 degrees
  asep_pkg::zang_t m, r, f;
  logic            fneg;
  always_comb begin
    m    = asep_pkg::Z_W'({v_q[N-1][5:0], lo_q[N-1]});
    r    = (m >= asep_pkg::DEG_HALF) ? m - asep_pkg::DEG_FULL : m;
    f    = r;
    fneg = 1'b0;
    if (r > asep_pkg::DEG_QUARTER) begin
      f    = r - asep_pkg::DEG_HALF;
      fneg = 1'b1;
    end else if (r < -asep_pkg::DEG_QUARTER) begin
      f    = r + asep_pkg::DEG_HALF;
      fneg = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_o   <= f;
      neg_o <= fneg;
    end
  end

endmodule

`default_nettype wire

// File: src/asep_sincos.sv
// ----------------------------------------------------------------------------
// asep_sincos
// rotation-mode cordic, one iteration per stage, cosine and sine in q30
// ----------------------------------------------------------------------------
`default_nettype none

module asep_sincos #(
  parameter int unsigned CORDIC_ITERATIONS = asep_pkg::CORDIC_ITERATIONS_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  wire asep_pkg::zang_t z_i,
  input  wire logic            neg_i,
  output asep_pkg::xy_t        c_o,
  output asep_pkg::xy_t        s_o
);

  localparam int unsigned N = CORDIC_ITERATIONS;

  asep_pkg::xy_t   x_q [N];
  asep_pkg::xy_t   y_q [N];
  asep_pkg::zang_t z_q [N];
  logic            n_q [N];

  for (genvar i = 0; i < N; i++) begin : g_iter
    asep_pkg::xy_t   xi, yi, dx, dy;
    asep_pkg::zang_t zi, at;
    logic            ni;
    if (i == 0) begin : g_first
      assign xi = asep_pkg::GAIN_Q30;
      assign yi = '0;
      assign zi = z_i;
      assign ni = neg_i;
    end else begin : g_next
      assign xi = x_q[i-1];
      assign yi = y_q[i-1];
      assign zi = z_q[i-1];
      assign ni = n_q[i-1];
    end
    assign dx = yi >>> i;
    assign dy = xi >>> i;
    assign at = asep_pkg::Z_W'(asep_pkg::atan_step(i));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!zi[asep_pkg::Z_W-1]) begin
          x_q[i] <= xi - dx;
          y_q[i] <= yi + dy;
          z_q[i] <= zi - at;
        end else begin
          x_q[i] <= xi + dx;
          y_q[i] <= yi - dy;
          z_q[i] <= zi + at;
        end
        n_q[i] <= ni;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_o <= n_q[N-1] ? -x_q[N-1] : x_q[N-1];
      s_o <= n_q[N-1] ? -y_q[N-1] : y_q[N-1];
    end
  end

endmodule

`default_nettype wire

// File: src/asep_sqrt.sv
// ----------------------------------------------------------------------------
// asep_sqrt
// floor square root, one result bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module asep_sqrt (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [asep_pkg::SQ_W-1:0]     n_i,
  output logic      [asep_pkg::ROOT_W-1:0]   root_o
);

  localparam int unsigned N = asep_pkg::SQ_STEPS;

  logic [asep_pkg::SQ_W-1:0] n_q   [N];
  logic [asep_pkg::SQ_W-1:0] res_q [N];

  for (genvar j = 0; j < N; j++) begin : g_digit
    logic [asep_pkg::SQ_W-1:0] ni, ri, bt, t;
    if (j == 0) begin : g_first
      assign ni = n_i;
      assign ri = '0;
    end else begin : g_next
      assign ni = n_q[j-1];
      assign ri = res_q[j-1];
    end
    assign bt = asep_pkg::SQ_W'(1) << (2 * (N - 1 - j));
    assign t  = ri + bt;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (ni >= t) begin
          n_q[j]   <= ni - t;
          res_q[j] <= (ri >> 1) + bt;
        end else begin
          n_q[j]   <= ni;
          res_q[j] <= ri >> 1;
        end
      end
    end
  end

  assign root_o = res_q[N-1][asep_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

// File: src/asep_vector.sv
// ----------------------------------------------------------------------------
// asep_vector
// vectoring-mode cordic, one iteration per stage, angle in degrees times 2^32
// ----------------------------------------------------------------------------
`default_nettype none

module asep_vector #(
  parameter int unsigned CORDIC_ITERATIONS = asep_pkg::CORDIC_ITERATIONS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire asep_pkg::xy_t x_i,
  input  wire asep_pkg::xy_t y_i,
  output asep_pkg::zang_t    z_o
);

  localparam int unsigned N = CORDIC_ITERATIONS;

  asep_pkg::xy_t   x_q [N];
  asep_pkg::xy_t   y_q [N];
  asep_pkg::zang_t z_q [N];

  for (genvar i = 0; i < N; i++) begin : g_iter
    asep_pkg::xy_t   xi, yi, dx, dy;
    asep_pkg::zang_t zi, at;
    if (i == 0) begin : g_first
      assign xi = x_i;
      assign yi = y_i;
      assign zi = '0;
    end else begin : g_next
      assign xi = x_q[i-1];
      assign yi = y_q[i-1];
      assign zi = z_q[i-1];
    end
    assign dx = yi >>> i;
    assign dy = xi >>> i;
    assign at = asep_pkg::Z_W'(asep_pkg::atan_step(i));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (yi > 0) begin
          x_q[i] <= xi + dx;
          y_q[i] <= yi - dy;
          z_q[i] <= zi + at;
        end else if (yi < 0) begin
          x_q[i] <= xi - dx;
          y_q[i] <= yi + dy;
          z_q[i] <= zi - at;
        end else begin
          // zero residual: nothing to rotate
          x_q[i] <= xi;
          y_q[i] <= yi;
          z_q[i] <= zi;
        end
      end
    end
  end

  assign z_o = z_q[N-1];

endmodule

`default_nettype wire

// File: src/angular_separation_haversine.sv
// ----------------------------------------------------------------------------
// angular_separation_haversine
// great-circle angle between two sky positions by the haversine formula
// ----------------------------------------------------------------------------
// throughput: one word per cycle while not stalled, every stage is a register stage on one enable
// the whole pipeline freezes only while the output word is held by out_stall_i
// reset clears the valid bits only, data registers come up undefined
// ----------------------------------------------------------------------------
`default_nettype none

module angular_separation_haversine #(
  parameter int unsigned ANGLE_FRAC_BITS   = asep_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int unsigned CORDIC_ITERATIONS = asep_pkg::CORDIC_ITERATIONS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [29:0] ra_first_i,
  input  wire logic signed [27:0] dec_first_i,
  input  wire logic signed [29:0] ra_second_i,
  input  wire logic signed [27:0] dec_second_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [asep_pkg::SEP_W-1:0] separation_o
);

  // pipeline depth: input reg, angle reduction, sincos, two multiply stages,
  // sum and clamp, square root, vectoring, output rounding
  localparam int unsigned LAT = 1 + (asep_pkg::RED_STEPS + 1) + (CORDIC_ITERATIONS + 1)
                              + 3 + asep_pkg::SQ_STEPS + CORDIC_ITERATIONS + 1;
  localparam int unsigned SH  = 32 - ANGLE_FRAC_BITS;

  localparam longint unsigned LIM_RAW = 64'd180 << ANGLE_FRAC_BITS;
  localparam longint unsigned LIM     = (LIM_RAW > asep_pkg::SEP_FIELD_MAX)
                                      ? asep_pkg::SEP_FIELD_MAX : LIM_RAW;
  localparam asep_pkg::zang_t ROUND_ADD = asep_pkg::Z_W'(1) << (30 - ANGLE_FRAC_BITS);

  // global enable: everything moves unless the output word is stalled
  logic en;
  logic [LAT-1:0] vld_q;

  assign en          = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // input word register
  logic signed [29:0] ra1_q, ra2_q;
  logic signed [27:0] de1_q, de2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ra1_q <= ra_first_i;
      de1_q <= dec_first_i;
      ra2_q <= ra_second_i;
      de2_q <= dec_second_i;
    end
  end

  // scale into degrees times 2^32, half differences
  asep_pkg::wide_t de1_w, de2_w, ddec_h, dra_h;
  always_comb begin
    de1_w  = asep_pkg::wide_t'(de1_q) <<< SH;
    de2_w  = asep_pkg::wide_t'(de2_q) <<< SH;
    ddec_h = (de2_w - de1_w) >>> 1;
    dra_h  = ((asep_pkg::wide_t'(ra2_q) - asep_pkg::wide_t'(ra1_q)) <<< SH) >>> 1;
  end

  // four angles reduced and fed to four cordic rotators
  asep_pkg::zang_t z1, z2, zd, zr;
  logic            n1, n2, nd, nr;

  asep_angle u_ang_de1 (.clk_i, .en_i(en), .ang_i(de1_w),  .z_o(z1), .neg_o(n1));
  asep_angle u_ang_de2 (.clk_i, .en_i(en), .ang_i(de2_w),  .z_o(z2), .neg_o(n2));
  asep_angle u_ang_dd  (.clk_i, .en_i(en), .ang_i(ddec_h), .z_o(zd), .neg_o(nd));
  asep_angle u_ang_dr  (.clk_i, .en_i(en), .ang_i(dra_h),  .z_o(zr), .neg_o(nr));

  asep_pkg::xy_t c1, c2, sd, sr;

  asep_sincos #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_sc_de1 (
    .clk_i, .en_i(en), .z_i(z1), .neg_i(n1), .c_o(c1), .s_o()
  );
  asep_sincos #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_sc_de2 (
    .clk_i, .en_i(en), .z_i(z2), .neg_i(n2), .c_o(c2), .s_o()
  );
  asep_sincos #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_sc_dd (
    .clk_i, .en_i(en), .z_i(zd), .neg_i(nd), .c_o(), .s_o(sd)
  );
  asep_sincos #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_sc_dr (
    .clk_i, .en_i(en), .z_i(zr), .neg_i(nr), .c_o(), .s_o(sr)
  );

  // first multiply stage: cos1 cos2, sin^2 of both half differences
  logic signed [2*asep_pkg::XY_W-1:0] p_full, sd_full, sr_full;
  asep_pkg::xy_t p_q, sdsq_q, srsq_q;

  assign p_full  = c1 * c2;
  assign sd_full = sd * sd;
  assign sr_full = sr * sr;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q    <= p_full[30 +: asep_pkg::XY_W];
      sdsq_q <= sd_full[30 +: asep_pkg::XY_W];
      srsq_q <= sr_full[30 +: asep_pkg::XY_W];
    end
  end

  // second multiply stage: cos product times sin^2(dra/2)
  logic signed [2*asep_pkg::XY_W-1:0] q_full;
  asep_pkg::xy_t q_q, sdsq2_q;

  assign q_full = p_q * srsq_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      q_q     <= q_full[30 +: asep_pkg::XY_W];
      sdsq2_q <= sdsq_q;
    end
  end

  // haversine term, clamped to [0, 1]
  logic signed [asep_pkg::XY_W:0] a_sum;
  logic [asep_pkg::A_W-1:0]       a_q;

  assign a_sum = (asep_pkg::XY_W+1)'(sdsq2_q) + (asep_pkg::XY_W+1)'(q_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (a_sum[asep_pkg::XY_W]) begin
        a_q <= '0;
      end else if (a_sum > (asep_pkg::XY_W+1)'(asep_pkg::ONE_Q30)) begin
        a_q <= asep_pkg::ONE_Q30;
      end else begin
        a_q <= a_sum[asep_pkg::A_W-1:0];
      end
    end
  end

  // sqrt(a) and sqrt(1 - a), both operands shifted up by 30
  logic [asep_pkg::SQ_W-1:0]   ny, nx;
  logic [asep_pkg::ROOT_W-1:0] ry, rx;
  logic [asep_pkg::A_W-1:0]    one_m_a;

  assign one_m_a = asep_pkg::ONE_Q30 - a_q;
  assign ny      = asep_pkg::SQ_W'(a_q) << 30;
  assign nx      = asep_pkg::SQ_W'(one_m_a) << 30;

  asep_sqrt u_sqrt_y (.clk_i, .en_i(en), .n_i(ny), .root_o(ry));
  asep_sqrt u_sqrt_x (.clk_i, .en_i(en), .n_i(nx), .root_o(rx));

  // atan2(sqrt(a), sqrt(1 - a))
  asep_pkg::zang_t zv;

  asep_vector #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_vec (
    .clk_i, .en_i(en),
    .x_i(asep_pkg::XY_W'(rx)), .y_i(asep_pkg::XY_W'(ry)),
    .z_o(zv)
  );

  // doubling folded into the rounding shift, then clamp to 180 degrees
  asep_pkg::zang_t zc, rnd;
  always_comb begin
    zc  = zv[asep_pkg::Z_W-1] ? '0 : zv;
    rnd = (zc + ROUND_ADD) >>> (31 - ANGLE_FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (rnd > asep_pkg::Z_W'(LIM)) begin
        separation_o <= asep_pkg::SEP_W'(LIM);
      end else begin
        separation_o <= rnd[asep_pkg::SEP_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// File: tb/asep_checker.sv
// ----------------------------------------------------------------------------
// asep_checker
// watches both channels, predicts each separation word in fixed point and
// compares it in order with what the block returns
// ----------------------------------------------------------------------------
module asep_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic signed [29:0]         ra_first_i,
  input  logic signed [27:0]         dec_first_i,
  input  logic signed [29:0]         ra_second_i,
  input  logic signed [27:0]         dec_second_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic [asep_pkg::SEP_W-1:0] separation_i,
  output int                         mismatches_o,
  output int                         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     FRAC  = 20;
  localparam int     ITERS = 24;
  localparam longint UNIT  = 64'sd1 << 30;
  localparam longint FULL  = 64'sd360 << 32;
  localparam longint HALF  = 64'sd180 << 32;
  localparam longint QUART = 64'sd90 << 32;
  localparam longint RADQ  = 64'sd246083499208;
  localparam longint GAIN  = 64'sd652032874;
  localparam longint SEPMAX = 64'sd268435455;

  logic [asep_pkg::SEP_W-1:0] sep_expected_q[$];

  function automatic longint arc_step(int i);
    longint tbl[16] = '{64'sd193273528320, 64'sd114096026022, 64'sd60285206653,
                        64'sd30601712202, 64'sd15360239180, 64'sd7687607525,
                        64'sd3844741810, 64'sd1922488225, 64'sd961258780,
                        64'sd480631223, 64'sd240315841, 64'sd120157949,
                        64'sd60078978, 64'sd30039489, 64'sd15019745, 64'sd7509872};
    if (i < 16) return tbl[i];
    return RADQ >>> i;
  endfunction

  // rotation cordic, angle in degrees times 2^32, results in q30
  function automatic void rotate_unit(input longint ang, output longint cs,
                                      output longint sn);
    longint r, x, y, z, dx, dy;
    bit     flip;
    r = ang % FULL;
    x = GAIN;
    y = 0;
    flip = 0;
    if (r >= HALF) r -= FULL;
    else if (r < -HALF) r += FULL;
    if (r > QUART) begin
      r -= HALF;
      flip = 1;
    end else if (r < -QUART) begin
      r += HALF;
      flip = 1;
    end
    z = r;
    for (int i = 0; i < ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arc_step(i);
      end else begin
        x += dx; y -= dy; z += arc_step(i);
      end
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [asep_pkg::SEP_W-1:0] predict_separation(
      longint ra1, longint de1, longint ra2, longint de2);
    longint c1, s1, c2, s2, cd, sd, cr, sr, p, a, x, y, z, dx, dy, res;
    ra1 = ra1 <<< (32 - FRAC);
    de1 = de1 <<< (32 - FRAC);
    ra2 = ra2 <<< (32 - FRAC);
    de2 = de2 <<< (32 - FRAC);
    rotate_unit(de1, c1, s1);
    rotate_unit(de2, c2, s2);
    rotate_unit((de2 - de1) >>> 1, cd, sd);
    rotate_unit((ra2 - ra1) >>> 1, cr, sr);
    p = (c1 * c2) >>> 30;
    a = ((sd * sd) >>> 30) + ((p * ((sr * sr) >>> 30)) >>> 30);
    if (a < 0) a = 0;
    if (a > UNIT) a = UNIT;
    y = longint'(int_root(longint'(a) << 30));
    x = longint'(int_root(longint'(UNIT - a) << 30));
    // vectoring: a zero residual leaves the angle alone
    z = 0;
    for (int i = 0; i < ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += arc_step(i);
      end else if (y < 0) begin
        x -= dx; y += dy; z -= arc_step(i);
      end
    end
    if (z < 0) z = 0;
    res = (z + (64'sd1 <<< (30 - FRAC))) >>> (31 - FRAC);
    if (res > (64'sd180 <<< FRAC)) res = 64'sd180 <<< FRAC;
    if (res > SEPMAX) res = SEPMAX;
    return res[asep_pkg::SEP_W-1:0];
  endfunction

  assign pending_o = sep_expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    logic [asep_pkg::SEP_W-1:0] want;
    if (!rst_ni) begin
      mismatches_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        sep_expected_q.push_back(predict_separation(ra_first_i, dec_first_i,
                                                    ra_second_i, dec_second_i));
      if (out_valid_i && !out_stall_i) begin
        if (sep_expected_q.size() == 0) begin
          if (mismatches_o < 10) $display("unexpected word: got %0d", separation_i);
          mismatches_o <= mismatches_o + 1;
        end else begin
          want = sep_expected_q.pop_front();
          if (want !== separation_i) begin
            if (mismatches_o < 10)
              $display("separation mismatch: expected %0d got %0d", want, separation_i);
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
    end
  end
endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the haversine separation block; a checker beside
// the block predicts every word and counts mismatches
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RA_HI  = 377487360;  // 360 degrees
  localparam int DEC_HI = 94371840;   // 90 degrees
  localparam int DEG    = 1 << 20;
  localparam int LIMIT  = 400000;

  // idle profiles per phase
  typedef enum int {PH_SEND_IDLE, PH_RECV_IDLE, PH_NO_IDLE} phase_e;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid;
  logic out_stall = 1'b0;
  logic signed [29:0] ra_first, ra_second;
  logic signed [27:0] dec_first, dec_second;
  logic [asep_pkg::SEP_W-1:0] separation;
  int     mismatches, pending;
  int     cycles = 0;
  phase_e phase;

  angular_separation_haversine dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .ra_first_i(ra_first), .dec_first_i(dec_first),
    .ra_second_i(ra_second), .dec_second_i(dec_second),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .separation_o(separation)
  );

  asep_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .ra_first_i(ra_first), .dec_first_i(dec_first),
    .ra_second_i(ra_second), .dec_second_i(dec_second),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .separation_i(separation),
    .mismatches_o(mismatches), .pending_o(pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // receiver stall: heavy in PH_SEND_IDLE, light in PH_RECV_IDLE, none otherwise
  always @(posedge clk) begin
    case (phase)
      PH_SEND_IDLE: out_stall <= ($urandom_range(99) < 67);
      PH_RECV_IDLE: out_stall <= ($urandom_range(99) < 9);
      default:      out_stall <= 1'b0;
    endcase
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[angular_separation_haversine] ERROR");
      $finish;
    end
  end

  // one word onto the input channel, with an optional idle gap first
  task automatic send_word(int ra1, int de1, int ra2, int de2);
    int gap;
    gap = (phase == PH_SEND_IDLE) ? 9 : (phase == PH_RECV_IDLE) ? 67 : 0;
    while ($urandom_range(99) < gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    ra_first   <= ra1[29:0];
    dec_first  <= de1[27:0];
    ra_second  <= ra2[29:0];
    dec_second <= de2[27:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold the input channel quiet until every word has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic int rnd_ra();
    return int'($urandom_range(2 * RA_HI)) - RA_HI;
  endfunction

  function automatic int rnd_dec();
    return int'($urandom_range(2 * DEC_HI)) - DEC_HI;
  endfunction

  initial begin
    int ra1, de1, ra2, de2, kind;
    phase      = PH_NO_IDLE;
    in_valid   = 0;
    ra_first   = '0;
    dec_first  = '0;
    ra_second  = '0;
    dec_second = '0;
    rst_n      = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed words
    send_word(0, 0, 0, 0);                          // identical points
    send_word(RA_HI, DEC_HI, RA_HI, DEC_HI);
    send_word(0, DEC_HI, 0, -DEC_HI);               // pole to pole
    send_word(0, 0, 180 * DEG, 0);                  // antipodal on the equator
    send_word(-RA_HI, -DEC_HI, RA_HI, DEC_HI);
    send_word(-(1 << 29), -(1 << 27), (1 << 29) - 1, (1 << 27) - 1);  // field extremes
    send_word((1 << 29) - 1, (1 << 27) - 1, -(1 << 29), -(1 << 27));
    send_word(0, 100 * DEG, 0, -100 * DEG);         // declination past the pole
    send_word(10 * DEG, 45 * DEG, 370 * DEG, 45 * DEG);  // ra wraps by a full turn
    send_word(-170 * DEG, 0, 170 * DEG, 0);         // short way across the seam
    send_word(0, 0, 1, 0);                          // one lsb apart
    send_word(5 * DEG, 30 * DEG, 5 * DEG, 30 * DEG + 1);
    send_word(0, 0, 90 * DEG, 0);
    send_word(0, 0, 0, 90 * DEG);
    send_word(123 * DEG, -60 * DEG, 303 * DEG, 60 * DEG);  // antipodal off-axis
    send_word(0, DEC_HI, 200 * DEG, DEC_HI);        // pole, ra irrelevant
    send_word(-1, -1, -1, -1);
    send_word(0, 0, 179 * DEG + DEG / 2, 0);
    send_word(0, 89 * DEG, 180 * DEG, 89 * DEG);
    send_word(0, -(1 << 27), 0, (1 << 27) - 1);
    drain();

    for (int n = 0; n < 950; n++) begin
      if (n == 0)   phase = PH_SEND_IDLE;
      if (n == 317) begin
        drain();
        phase = PH_RECV_IDLE;
      end
      if (n == 634) phase = PH_NO_IDLE;
      kind = $urandom_range(9);
      if (kind < 5) begin
        ra1 = rnd_ra(); de1 = rnd_dec(); ra2 = rnd_ra(); de2 = rnd_dec();
      end else if (kind < 7) begin
        // nearby points, small separations
        ra1 = rnd_ra(); de1 = rnd_dec();
        ra2 = ra1 + int'($urandom_range(2000)) - 1000;
        de2 = de1 + int'($urandom_range(2000)) - 1000;
        if (de2 > DEC_HI) de2 = DEC_HI;
        if (de2 < -DEC_HI) de2 = -DEC_HI;
      end else if (kind < 8) begin
        // near antipodal
        ra1 = rnd_ra(); de1 = rnd_dec();
        ra2 = ra1 + 180 * DEG + int'($urandom_range(4000)) - 2000;
        de2 = -de1 + int'($urandom_range(4000)) - 2000;
        if (ra2 > (1 << 29) - 1) ra2 -= 360 * DEG;
        if (de2 > (1 << 27) - 1) de2 = (1 << 27) - 1;
        if (de2 < -(1 << 27)) de2 = -(1 << 27);
      end else if (kind < 9) begin
        // full raw field width
        ra1 = $urandom; de1 = $urandom; ra2 = $urandom; de2 = $urandom;
      end else begin
        ra1 = rnd_ra(); de1 = rnd_dec(); ra2 = ra1; de2 = de1;
      end
      send_word(ra1, de1, ra2, de2);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (mismatches == 0)
      $display("[angular_separation_haversine] OK");
    else
      $display("[angular_separation_haversine] ERROR");
    $finish;
  end
endmodule

// File: files.f
src/asep_pkg.sv
src/asep_angle.sv
src/asep_sincos.sv
src/asep_sqrt.sv
src/asep_vector.sv
src/angular_separation_haversine.sv
tb/asep_checker.sv
tb/tb.sv
